FILE: hw/rtl/fgs_pkg.sv
// Shared types, constants and the servo duty function of the feeder gate sequencer.
`default_nettype none

package fgs_pkg;

   localparam int DUTY_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int PULSE_MIN_US = 500;
   localparam int PULSE_MAX_US = 2400;
   localparam int PERIOD_US = 20000;
   localparam int ANGLE_MAX = 180;
   localparam int ANGLE_COUNT = ANGLE_MAX + 1;
   localparam int GRAMS_PER_STEP = 10;

   localparam int ANGLE_BITS = 8;
   localparam int MS_BITS = 16;
   localparam int PWM_OUT_BITS = 16;
   localparam int GRAMS_BITS = 16;

   // Division of the target by ten is a multiplication by a scaled reciprocal.
   localparam int DIV10_SHIFT = 19;
   localparam int DIV10_MULT = (1 << DIV10_SHIFT) / GRAMS_PER_STEP + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [ANGLE_BITS-1:0] OPEN_ANGLE_RESET = 8'd70;
   localparam logic [ANGLE_BITS-1:0] CLOSED_ANGLE_RESET = 8'd0;
   localparam logic [MS_BITS-1:0] MOVE_TIME_RESET = 16'd200;
   localparam logic [MS_BITS-1:0] HOLD_MIN_RESET = 16'd300;
   localparam logic [MS_BITS-1:0] HOLD_MAX_RESET = 16'd1500;
   localparam logic [MS_BITS-1:0] HOLD_STEP_RESET = 16'd120;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_SET_LED,
      CMD_SET_FAN,
      CMD_SET_PUMP,
      CMD_START_FEED,
      CMD_STOP_FEED,
      CMD_TAKE_OK,
      CMD_TAKE_TIMEOUT
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_OPEN_ANGLE,
      CSR_CLOSED_ANGLE,
      CSR_MOVE_TIME,
      CSR_HOLD_MIN,
      CSR_HOLD_MAX,
      CSR_HOLD_STEP
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_OPENING,
      PHASE_HOLDING,
      PHASE_CLOSING
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_PUMP_INTERLOCK,
      ERR_FEED_INTERLOCK,
      ERR_FEED_TIMEOUT
   } error_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD_DIV,
      ST_HOLD_MUL,
      ST_HOLD_SUM,
      ST_FEED,
      ST_TICK,
      ST_SETTLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [31:0] now_ms;
      logic switch_on;
      logic [31:0] run_limit_ms;
      logic signed [GRAMS_BITS-1:0] target_grams;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic flag_taken;
      logic led_state;
      logic fan_state;
      logic pump_state;
      logic gate_busy;
      logic [1:0] phase_now;
      logic [ANGLE_BITS-1:0] gate_angle;
      logic [PWM_OUT_BITS-1:0] pwm_duty;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec_simple;
      logic hold_div;
      logic hold_mul;
      logic hold_sum;
      logic feed_start;
      logic tick_pass;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic feed_allowed;
      logic tick_last;
   } dp_status_type;

   function automatic longint unsigned duty_calc(input int unsigned angle,
                                                 input int unsigned duty_bits);
      longint unsigned span;
      longint unsigned pulse;
      longint unsigned dmax;
      span = PULSE_MAX_US - PULSE_MIN_US;
      pulse = PULSE_MIN_US + (span * angle) / ANGLE_MAX;
      dmax = (64'd1 << duty_bits) - 64'd1;
      return (pulse * dmax) / PERIOD_US;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fgs_ctrl.sv
// Controller state machine that steps each transaction through the datapath.
`default_nettype none

module fgs_ctrl
   import fgs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   input  wire dp_status_type dp_status,
   output dp_cmd_type dp_cmd
);

   state_type state_ff;
   state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_status.command == CMD_TICK) begin
               state_in = ST_TICK;
            end else if (dp_status.command == CMD_START_FEED && dp_status.feed_allowed) begin
               state_in = ST_HOLD_DIV;
            end else begin
               dp_cmd.exec_simple = 1'b1;
               state_in = ST_SETTLE;
            end
         end
         ST_HOLD_DIV: begin
            dp_cmd.hold_div = 1'b1;
            state_in = ST_HOLD_MUL;
         end
         ST_HOLD_MUL: begin
            dp_cmd.hold_mul = 1'b1;
            state_in = ST_HOLD_SUM;
         end
         ST_HOLD_SUM: begin
            dp_cmd.hold_sum = 1'b1;
            state_in = ST_FEED;
         end
         ST_FEED: begin
            dp_cmd.feed_start = 1'b1;
            state_in = ST_SETTLE;
         end
         ST_TICK: begin
            dp_cmd.tick_pass = 1'b1;
            if (dp_status.tick_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fgs_datapath.sv
// Datapath with configuration, switch, sequence and timing registers of the gate sequencer.
`default_nettype none

module fgs_datapath
   import fgs_pkg::*;
#(
   parameter int DUTY_BITS = DUTY_BITS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire req_type req_data,
   input  wire dp_cmd_type dp_cmd,
   output dp_status_type dp_status,
   output rsp_type rsp_data
);

   localparam int GRAMS_MAG_BITS = GRAMS_BITS - 1;
   localparam int DIV_PRODUCT_BITS = GRAMS_MAG_BITS + 16;
   localparam int QUOT_BITS = DIV_PRODUCT_BITS - DIV10_SHIFT;
   localparam int HOLD_PROD_BITS = QUOT_BITS + MS_BITS;
   localparam int HOLD_SUM_BITS = HOLD_PROD_BITS + 1;
   localparam int RUN_NEED_BITS = MS_BITS + 2;
   localparam int CMP_BITS = 32;

   function automatic logic [ANGLE_BITS-1:0] clamp_angle(input logic [ANGLE_BITS-1:0] a);
      return (a > ANGLE_BITS'(ANGLE_MAX)) ? ANGLE_BITS'(ANGLE_MAX) : a;
   endfunction

   logic [DUTY_BITS-1:0] duty_rom [ANGLE_COUNT];

   for (genvar a = 0; a < ANGLE_COUNT; a++) begin : g_duty_rom
      assign duty_rom[a] = DUTY_BITS'(duty_calc(a, DUTY_BITS));
   end

   logic [ANGLE_BITS-1:0] open_angle_ff;
   logic [ANGLE_BITS-1:0] closed_angle_ff;
   logic [MS_BITS-1:0] move_time_ff;
   logic [MS_BITS-1:0] hold_min_ff;
   logic [MS_BITS-1:0] hold_max_ff;
   logic [MS_BITS-1:0] hold_step_ff;

   req_type req_ff, req_in;
   logic led_ff, led_in;
   logic fan_ff, fan_in;
   logic pump_ff, pump_in;
   logic busy_ff, busy_in;
   phase_type phase_ff, phase_in;
   logic [TIME_BITS-1:0] pdl_ff, pdl_in;
   logic [TIME_BITS-1:0] tdl_ff, tdl_in;
   logic [MS_BITS-1:0] hold_ff, hold_in;
   logic armed_ff, armed_in;
   logic ok_flag_ff, ok_flag_in;
   logic to_flag_ff, to_flag_in;
   error_type err_ff, err_in;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [DUTY_BITS-1:0] duty_ff;
   logic accepted_ff, accepted_in;
   logic taken_ff, taken_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [HOLD_PROD_BITS-1:0] prod_ff, prod_in;
   rsp_type rsp_ff, rsp_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] max_t;
   logic grams_pos;
   logic [GRAMS_MAG_BITS-1:0] grams_mag;
   logic [DIV_PRODUCT_BITS-1:0] div_product;
   logic [HOLD_SUM_BITS-1:0] hold_sum;
   logic [RUN_NEED_BITS-1:0] run_need;
   logic arm_need;
   logic timeout_hit;
   logic deadline_wait;
   logic end_seq;
   logic [DUTY_BITS+PWM_OUT_BITS-1:0] duty_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_angle_ff <= OPEN_ANGLE_RESET;
         closed_angle_ff <= CLOSED_ANGLE_RESET;
         move_time_ff <= MOVE_TIME_RESET;
         hold_min_ff <= HOLD_MIN_RESET;
         hold_max_ff <= HOLD_MAX_RESET;
         hold_step_ff <= HOLD_STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_OPEN_ANGLE: open_angle_ff <= csr_wdata[ANGLE_BITS-1:0];
            CSR_CLOSED_ANGLE: closed_angle_ff <= csr_wdata[ANGLE_BITS-1:0];
            CSR_MOVE_TIME: move_time_ff <= csr_wdata[MS_BITS-1:0];
            CSR_HOLD_MIN: hold_min_ff <= csr_wdata[MS_BITS-1:0];
            CSR_HOLD_MAX: hold_max_ff <= csr_wdata[MS_BITS-1:0];
            CSR_HOLD_STEP: hold_step_ff <= csr_wdata[MS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 1'b0;
         fan_ff <= 1'b0;
         pump_ff <= 1'b0;
         busy_ff <= 1'b0;
         phase_ff <= PHASE_IDLE;
         pdl_ff <= '0;
         tdl_ff <= '0;
         hold_ff <= '0;
         armed_ff <= 1'b0;
         ok_flag_ff <= 1'b0;
         to_flag_ff <= 1'b0;
         err_ff <= ERR_NONE;
         angle_ff <= clamp_angle(CLOSED_ANGLE_RESET);
         duty_ff <= duty_rom[clamp_angle(CLOSED_ANGLE_RESET)];
      end else begin
         led_ff <= led_in;
         fan_ff <= fan_in;
         pump_ff <= pump_in;
         busy_ff <= busy_in;
         phase_ff <= phase_in;
         pdl_ff <= pdl_in;
         tdl_ff <= tdl_in;
         hold_ff <= hold_in;
         armed_ff <= armed_in;
         ok_flag_ff <= ok_flag_in;
         to_flag_ff <= to_flag_in;
         err_ff <= err_in;
         angle_ff <= angle_in;
         duty_ff <= duty_rom[angle_ff];
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      accepted_ff <= accepted_in;
      taken_ff <= taken_in;
      quot_ff <= quot_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   assign now_t = req_ff.now_ms[TIME_BITS-1:0];
   assign max_t = req_ff.run_limit_ms[TIME_BITS-1:0];
   assign grams_pos = !req_ff.target_grams[GRAMS_BITS-1] && (req_ff.target_grams != '0);
   assign grams_mag = req_ff.target_grams[GRAMS_MAG_BITS-1:0];
   assign div_product = DIV_PRODUCT_BITS'(grams_mag) * DIV_PRODUCT_BITS'(DIV10_MULT);
   assign hold_sum = HOLD_SUM_BITS'(hold_min_ff) + HOLD_SUM_BITS'(prod_ff);
   assign run_need = RUN_NEED_BITS'({move_time_ff, 1'b0}) + RUN_NEED_BITS'(hold_ff);
   assign arm_need = CMP_BITS'(run_need) > CMP_BITS'(max_t);
   assign timeout_hit = armed_ff && (now_t >= tdl_ff);
   assign deadline_wait = now_t < pdl_ff;
   assign duty_wide = {{PWM_OUT_BITS{1'b0}}, duty_ff};

   always_comb begin
      req_in = req_ff;
      led_in = led_ff;
      fan_in = fan_ff;
      pump_in = pump_ff;
      busy_in = busy_ff;
      phase_in = phase_ff;
      pdl_in = pdl_ff;
      tdl_in = tdl_ff;
      hold_in = hold_ff;
      armed_in = armed_ff;
      ok_flag_in = ok_flag_ff;
      to_flag_in = to_flag_ff;
      err_in = err_ff;
      angle_in = angle_ff;
      accepted_in = accepted_ff;
      taken_in = taken_ff;
      quot_in = quot_ff;
      prod_in = prod_ff;
      rsp_in = rsp_ff;
      end_seq = 1'b0;

      if (dp_cmd.capture) begin
         req_in = req_data;
         accepted_in = 1'b1;
         taken_in = 1'b0;
      end

      if (dp_cmd.exec_simple) begin
         unique case (cmd_type'(req_ff.command))
            CMD_SET_LED: led_in = req_ff.switch_on;
            CMD_SET_FAN: fan_in = req_ff.switch_on;
            CMD_SET_PUMP: begin
               if (req_ff.switch_on && busy_ff) begin
                  err_in = ERR_PUMP_INTERLOCK;
                  accepted_in = 1'b0;
               end else begin
                  pump_in = req_ff.switch_on;
               end
            end
            CMD_START_FEED: begin
               err_in = ERR_FEED_INTERLOCK;
               accepted_in = 1'b0;
            end
            CMD_STOP_FEED: end_seq = 1'b1;
            CMD_TAKE_OK: begin
               taken_in = ok_flag_ff;
               ok_flag_in = 1'b0;
            end
            CMD_TAKE_TIMEOUT: begin
               taken_in = to_flag_ff;
               to_flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (dp_cmd.hold_div) begin
         quot_in = grams_pos ? div_product[DIV_PRODUCT_BITS-1:DIV10_SHIFT] : '0;
      end

      if (dp_cmd.hold_mul) begin
         prod_in = HOLD_PROD_BITS'(quot_ff) * HOLD_PROD_BITS'(hold_step_ff);
      end

      if (dp_cmd.hold_sum) begin
         hold_in = (hold_sum > HOLD_SUM_BITS'(hold_max_ff)) ? hold_max_ff
                                                             : hold_sum[MS_BITS-1:0];
      end

      if (dp_cmd.feed_start) begin
         busy_in = 1'b1;
         err_in = ERR_NONE;
         phase_in = PHASE_OPENING;
         pdl_in = now_t + TIME_BITS'(move_time_ff);
         armed_in = arm_need;
         tdl_in = arm_need ? (now_t + max_t) : '0;
         ok_flag_in = 1'b0;
         to_flag_in = 1'b0;
         angle_in = clamp_angle(open_angle_ff);
      end

      if (dp_cmd.tick_pass && phase_ff != PHASE_IDLE) begin
         if (timeout_hit) begin
            end_seq = 1'b1;
            err_in = ERR_FEED_TIMEOUT;
            to_flag_in = 1'b1;
            ok_flag_in = 1'b0;
         end else if (!deadline_wait) begin
            case (phase_ff)
               PHASE_OPENING: begin
                  phase_in = PHASE_HOLDING;
                  pdl_in = now_t + TIME_BITS'(hold_ff);
               end
               PHASE_HOLDING: begin
                  phase_in = PHASE_CLOSING;
                  angle_in = clamp_angle(closed_angle_ff);
                  pdl_in = now_t + TIME_BITS'(move_time_ff);
               end
               default: begin
                  end_seq = 1'b1;
                  to_flag_in = 1'b0;
                  ok_flag_in = 1'b1;
               end
            endcase
         end
      end

      if (end_seq) begin
         busy_in = 1'b0;
         phase_in = PHASE_IDLE;
         pdl_in = '0;
         tdl_in = '0;
         hold_in = '0;
         armed_in = 1'b0;
         angle_in = clamp_angle(closed_angle_ff);
      end

      if (dp_cmd.load_rsp) begin
         rsp_in.accepted = accepted_ff;
         rsp_in.flag_taken = taken_ff;
         rsp_in.led_state = led_ff;
         rsp_in.fan_state = fan_ff;
         rsp_in.pump_state = pump_ff;
         rsp_in.gate_busy = busy_ff;
         rsp_in.phase_now = phase_ff;
         rsp_in.gate_angle = angle_ff;
         rsp_in.pwm_duty = duty_wide[PWM_OUT_BITS-1:0];
         rsp_in.error_code = err_ff;
      end
   end

   assign dp_status.command = cmd_type'(req_ff.command);
   assign dp_status.feed_allowed = !pump_ff && !busy_ff;
   assign dp_status.tick_last = (phase_ff == PHASE_IDLE) || timeout_hit || deadline_wait
                                || (phase_ff == PHASE_CLOSING);
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/feeder_gate_sequencer_core.sv
// Top level of the feeder gate sequencer: controller, datapath and channel ports.
//
//   Channel   Handshake               Contents
//   req_      req_valid / req_stall   command, now_ms, switch_on, run_limit_ms, target_grams
//   rsp_      rsp_valid / rsp_stall   switch, sequence, angle, duty and error status
//   csr_      csr_valid / csr_ready   register index and write data
//
// A switch, stop or take command passes through the execute, settle and result states after acceptance.
// A tick stays in the phase loop state until its last pass, then goes through the settle and result states.
// An allowed start_feed adds the three-step hold time calculation (divide, multiply, sum) and the feed state.
// The next transaction can be accepted while the result is offered.
// Reset is synchronous; it restores the control, status and configuration registers.
// The result register holds a stalled transaction; only the result load waits for it.
`default_nettype none

module feeder_gate_sequencer_core
   import fgs_pkg::*;
#(
   parameter int DUTY_BITS = DUTY_BITS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   dp_cmd_type dp_cmd;
   dp_status_type dp_status;
   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   fgs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .dp_status(dp_status),
      .dp_cmd(dp_cmd)
   );

   fgs_datapath #(
      .DUTY_BITS(DUTY_BITS),
      .TIME_BITS(TIME_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data(req_data),
      .dp_cmd(dp_cmd),
      .dp_status(dp_status),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/fgs_checker.sv
// Port-level assertions for the feeder gate sequencer and their bind to the top level.
`default_nettype none

module fgs_checker
   import fgs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result transaction stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // Only one request transaction is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in work");

   // The busy flag and the phase agree in every result.
   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.gate_busy == (rsp_data.phase_now != PHASE_IDLE)))
      else $error("busy flag disagrees with phase");

   // A rejected command always leaves an interlock error behind.
   a_reject_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         (rsp_data.error_code == ERR_PUMP_INTERLOCK || rsp_data.error_code == ERR_FEED_INTERLOCK))
      else $error("rejected command without interlock error");

endmodule

bind feeder_gate_sequencer_core fgs_checker u_fgs_checker (.*);

`default_nettype wire
